FILE: rtl/csd_pkg.sv
`default_nettype none

package csd_pkg;

    // fixed field widths
    localparam int unsigned TAG_BITS     = 6;
    localparam int unsigned OUT_KEY_BITS = 32;

    // gap shrink: g * 10 / 13, with 9 or 10 raised to 11 and a floor of 1
    localparam int unsigned SHRINK_MUL   = 10;
    localparam int unsigned SHRINK_DIV   = 13;
    // floor(2^16 / 13), the reciprocal estimate never overshoots the quotient
    localparam int unsigned RECIP_SHIFT  = 16;
    localparam int unsigned RECIP        = (1 << RECIP_SHIFT) / SHRINK_DIV;
    localparam int unsigned RECIP_MUL    = SHRINK_MUL * RECIP;
    localparam int unsigned RECIP_BITS   = 16;
    localparam int unsigned GAP_LOW      = 9;
    localparam int unsigned GAP_HIGH     = 10;
    localparam int unsigned GAP_JUMP     = 11;

    // sequencer states
    typedef enum logic [3:0] {
        S_LOAD,
        S_PASS_CHK,
        S_SHR1,
        S_SHR2,
        S_RD,
        S_CMP,
        S_WR2,
        S_EMIT_RD,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/csd_ram.sv
`default_nettype none

module csd_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // two registered read ports, read before write
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

FILE: rtl/csd_shrink.sv
`default_nettype none

module csd_shrink #(
    parameter int GAP_BITS = 7
) (
    input  wire logic                i_clk,
    input  wire logic [GAP_BITS-1:0] i_gap,
    output logic      [GAP_BITS-1:0] o_gap_next
);

    localparam int XW = GAP_BITS + 4;
    localparam int PW = GAP_BITS + csd_pkg::RECIP_BITS;

    logic [XW-1:0] r_x;
    logic [XW-1:0] r_q0;
    logic [PW-1:0] prod;
    logic [XW-1:0] rem;
    logic [XW-1:0] quo;
    logic [XW-1:0] gap_n;

    // stage one: g*10 and a quotient estimate that is exact or one low
    assign prod = PW'(i_gap) * PW'(csd_pkg::RECIP_MUL);

    always_ff @(posedge i_clk) begin
        r_x  <= XW'(i_gap) * XW'(csd_pkg::SHRINK_MUL);
        r_q0 <= XW'(prod >> csd_pkg::RECIP_SHIFT);
    end

    // stage two: one correction step, then the 11 rule and the floor
    always_comb begin
        rem = r_x - r_q0 * XW'(csd_pkg::SHRINK_DIV);
        quo = r_q0;
        if (rem >= XW'(csd_pkg::SHRINK_DIV)) begin
            quo = r_q0 + XW'(1);
        end
        gap_n = quo;
        if (quo == XW'(csd_pkg::GAP_LOW) || quo == XW'(csd_pkg::GAP_HIGH)) begin
            gap_n = XW'(csd_pkg::GAP_JUMP);
        end
        if (quo == '0) begin
            gap_n = XW'(1);
        end
    end

    assign o_gap_next = GAP_BITS'(gap_n);

endmodule

`default_nettype wire

FILE: rtl/comb_sort_descending_top.sv
`default_nettype none

// channel   dir  valid         stall         payload
// input     in   i_in_valid    o_in_stall    i_distance_key, i_item_tag, i_last_in
// output    out  o_out_valid   i_out_stall   o_sorted_key, o_sorted_tag, o_last_out, o_overflow
//
// loading takes one item per cycle; the sort starts after the item marked last
// each pass runs S_PASS_CHK, S_SHR1 and S_SHR2 for the gap update, then S_RD and
// S_CMP per compare and S_WR2 per swap, as the pair store has one write port
// the burst then starts with S_EMIT_RD and is paced by the output stall
// reset is synchronous and clears the control state; the store needs no clearing
// the input is stalled from the last item until the burst is handed out; a
// stalled result waits in the output register while loading goes on

module comb_sort_descending_top #(
    parameter int MAX_ITEMS = 64,
    parameter int KEY_BITS  = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [31:0]                        i_distance_key,
    input  wire logic [csd_pkg::TAG_BITS-1:0]       i_item_tag,
    input  wire logic                               i_last_in,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic      [csd_pkg::OUT_KEY_BITS-1:0]   o_sorted_key,
    output logic      [csd_pkg::TAG_BITS-1:0]       o_sorted_tag,
    output logic                                    o_last_out,
    output logic                                    o_overflow
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int TW = csd_pkg::TAG_BITS;
    localparam int DW = KEY_BITS + TW;
    localparam int OW = csd_pkg::OUT_KEY_BITS;

    csd_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_gap, n_gap;
    logic          r_swap, n_swap;
    logic          r_ovf, n_ovf;
    logic [AW-1:0] r_idx, n_idx;
    logic [DW-1:0] r_hold, n_hold;
    logic          r_out_valid, n_out_valid;
    logic [OW-1:0] r_out_key, n_out_key;
    logic [TW-1:0] r_out_tag, n_out_tag;
    logic          r_out_last, n_out_last;
    logic          r_out_ovf, n_out_ovf;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr_a;
    logic [DW-1:0] ram_rdata_a;
    logic [DW-1:0] ram_rdata_b;
    logic [AW-1:0] pair_addr;
    logic [CW-1:0] gap_new;

    logic          in_fire;
    logic          store_ok;
    logic          do_swap;
    logic [CW:0]   j_next;
    logic          more;
    logic          out_free;
    logic          emit_fire;
    logic          emit_last;

    // pair store: key above tag
    csd_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (ram_rdata_a),
        .i_raddr_b (pair_addr),
        .o_rdata_b (ram_rdata_b)
    );

    // gap update unit, result valid in the cycle after the gap settles
    csd_shrink #(
        .GAP_BITS (CW)
    ) u_shrink (
        .i_clk      (i_clk),
        .i_gap      (r_gap),
        .o_gap_next (gap_new)
    );

    // shared decode
    assign in_fire   = i_in_valid && (r_state == csd_pkg::S_LOAD);
    assign store_ok  = r_count < CW'(MAX_ITEMS);
    assign do_swap   = ram_rdata_a[DW-1:TW] < ram_rdata_b[DW-1:TW];
    assign pair_addr = AW'(CW'(r_idx) + r_gap);
    assign j_next    = (CW+1)'(r_idx) + (CW+1)'(r_gap) + (CW+1)'(1);
    assign more      = j_next < (CW+1)'(r_count);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit_fire = (r_state == csd_pkg::S_EMIT) && out_free;
    assign emit_last = (CW'(r_idx) + CW'(1)) == r_count;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            csd_pkg::S_LOAD: begin
                if (in_fire && i_last_in) begin
                    n_state = csd_pkg::S_PASS_CHK;
                end
            end
            csd_pkg::S_PASS_CHK: begin
                if (r_gap > CW'(1) || r_swap) begin
                    n_state = csd_pkg::S_SHR1;
                end else begin
                    n_state = csd_pkg::S_EMIT_RD;
                end
            end
            csd_pkg::S_SHR1: begin
                n_state = csd_pkg::S_SHR2;
            end
            csd_pkg::S_SHR2: begin
                if (gap_new >= r_count) begin
                    n_state = csd_pkg::S_PASS_CHK;
                end else begin
                    n_state = csd_pkg::S_RD;
                end
            end
            csd_pkg::S_RD: begin
                n_state = csd_pkg::S_CMP;
            end
            csd_pkg::S_CMP: begin
                if (do_swap) begin
                    n_state = csd_pkg::S_WR2;
                end else if (more) begin
                    n_state = csd_pkg::S_RD;
                end else begin
                    n_state = csd_pkg::S_PASS_CHK;
                end
            end
            csd_pkg::S_WR2: begin
                if (more) begin
                    n_state = csd_pkg::S_RD;
                end else begin
                    n_state = csd_pkg::S_PASS_CHK;
                end
            end
            csd_pkg::S_EMIT_RD: begin
                n_state = csd_pkg::S_EMIT;
            end
            csd_pkg::S_EMIT: begin
                if (emit_fire && emit_last) begin
                    n_state = csd_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = csd_pkg::S_LOAD;
            end
        endcase
    end

    // store port control and input stall
    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = ram_rdata_a;
        ram_raddr_a = r_idx;
        o_in_stall  = (r_state != csd_pkg::S_LOAD);
        unique case (r_state)
            csd_pkg::S_LOAD: begin
                ram_we    = in_fire && store_ok;
                ram_waddr = AW'(r_count);
                ram_wdata = {KEY_BITS'(i_distance_key), i_item_tag};
            end
            csd_pkg::S_CMP: begin
                // earlier entry moves up to the later slot
                ram_we    = do_swap;
                ram_waddr = pair_addr;
                ram_wdata = ram_rdata_a;
            end
            csd_pkg::S_WR2: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = r_hold;
            end
            csd_pkg::S_EMIT: begin
                if (emit_fire) begin
                    ram_raddr_a = r_idx + AW'(1);
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_count     = r_count;
        n_gap       = r_gap;
        n_swap      = r_swap;
        n_ovf       = r_ovf;
        n_idx       = r_idx;
        n_hold      = r_hold;
        n_out_key   = r_out_key;
        n_out_tag   = r_out_tag;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            csd_pkg::S_LOAD: begin
                if (in_fire) begin
                    if (store_ok) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_in) begin
                        n_gap  = store_ok ? r_count + CW'(1) : r_count;
                        n_swap = 1'b0;
                    end
                end
            end
            csd_pkg::S_PASS_CHK: begin
                n_idx = '0;
            end
            csd_pkg::S_SHR2: begin
                n_gap  = gap_new;
                n_swap = 1'b0;
                n_idx  = '0;
            end
            csd_pkg::S_CMP: begin
                if (do_swap) begin
                    n_swap = 1'b1;
                    n_hold = ram_rdata_b;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            csd_pkg::S_WR2: begin
                n_idx = r_idx + AW'(1);
            end
            csd_pkg::S_EMIT: begin
                if (emit_fire) begin
                    n_out_valid = 1'b1;
                    n_out_key   = OW'(ram_rdata_a[DW-1:TW]);
                    n_out_tag   = ram_rdata_a[TW-1:0];
                    n_out_last  = emit_last;
                    n_out_ovf   = r_ovf;
                    if (emit_last) begin
                        n_count = '0;
                        n_gap   = '0;
                        n_swap  = 1'b0;
                        n_ovf   = 1'b0;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csd_pkg::S_LOAD;
            r_count     <= '0;
            r_gap       <= '0;
            r_swap      <= 1'b0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_gap       <= n_gap;
            r_swap      <= n_swap;
            r_ovf       <= n_ovf;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hold     <= n_hold;
        r_out_key  <= n_out_key;
        r_out_tag  <= n_out_tag;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_out_valid  = r_out_valid;
    assign o_sorted_key = r_out_key;
    assign o_sorted_tag = r_out_tag;
    assign o_last_out   = r_out_last;
    assign o_overflow   = r_out_ovf;

endmodule

`default_nettype wire
